/* sv/tgcs_pkg.sv */
// ---------------------------------------------------------------------------
// tgcs_pkg
// Shared widths, codes, reset values and types of the text grid block.
// ---------------------------------------------------------------------------
package tgcs_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 8;

  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 8;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 6;
  localparam int OP_W       = 3;
  localparam int FONT_W     = 8;
  localparam int PANEL_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int DEPTH     = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int NROW_W    = $clog2(MAX_ROWS + 1);
  localparam int NCOL_W    = $clog2(MAX_COLUMNS + 1);
  localparam int DIV_STEPS = PANEL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_POS = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_ROW = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_COL = 3'd3;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd4;
  localparam logic [OP_W-1:0] OP_BLANK   = 3'd5;
  localparam logic [OP_W-1:0] OP_READ    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_FONT_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK   = 3'd5;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_RST    = 8'd32;

  localparam int FONT_W_RST  = 6;
  localparam int FONT_H_RST  = 8;
  localparam int PANEL_W_RST = 128;
  localparam int PANEL_H_RST = 64;

  localparam int ROWS_RAW = PANEL_H_RST / FONT_H_RST;
  localparam int COLS_RAW = PANEL_W_RST / FONT_W_RST;
  localparam int ROWS_RST = (ROWS_RAW > MAX_ROWS) ? MAX_ROWS :
                            ((ROWS_RAW == 0) ? 1 : ROWS_RAW);
  localparam int COLS_RST = (COLS_RAW > MAX_COLUMNS) ? MAX_COLUMNS :
                            ((COLS_RAW == 0) ? 1 : COLS_RAW);

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [PANEL_W-1:0] quot;
    logic               rem_nz;
  } div_res_t;

endpackage

/* sv/tgcs_div.sv */
// ---------------------------------------------------------------------------
// tgcs_div
// Iterative restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tgcs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tgcs_pkg::PANEL_W-1:0] dividend_i,
  input  logic [tgcs_pkg::FONT_W-1:0]  divisor_i,
  output tgcs_pkg::div_res_t          res_o
);

  logic [tgcs_pkg::PANEL_W-1:0]   acc_q;
  logic [tgcs_pkg::FONT_W-1:0]    rem_q;
  logic [tgcs_pkg::FONT_W-1:0]    dvs_q;
  logic [tgcs_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  logic [tgcs_pkg::FONT_W:0]   trial;
  logic [tgcs_pkg::FONT_W:0]   diff;
  logic                        ge;
  logic [tgcs_pkg::FONT_W-1:0] rem_d;
  logic [tgcs_pkg::PANEL_W-1:0] acc_d;

  always_comb begin
    trial = {rem_q, acc_q[tgcs_pkg::PANEL_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[tgcs_pkg::FONT_W-1:0] : trial[tgcs_pkg::FONT_W-1:0];
    acc_d = {acc_q[tgcs_pkg::PANEL_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      acc_q  <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= (divisor_i == '0) ? tgcs_pkg::FONT_W'(1) : divisor_i;
      cnt_q  <= tgcs_pkg::DIV_CNT_W'(tgcs_pkg::DIV_STEPS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q - tgcs_pkg::DIV_CNT_W'(1);
      if (cnt_q == tgcs_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign res_o.busy   = busy_q;
  assign res_o.done   = done_q;
  assign res_o.quot   = acc_q;
  assign res_o.rem_nz = |rem_q;

endmodule

/* sv/tgcs_cell_ram.sv */
// ---------------------------------------------------------------------------
// tgcs_cell_ram
// Character cell store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tgcs_cell_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [tgcs_pkg::ADDR_W-1:0] waddr_i,
  input  logic [tgcs_pkg::CHAR_W-1:0] wdata_i,
  input  logic [tgcs_pkg::ADDR_W-1:0] raddr_i,
  output logic [tgcs_pkg::CHAR_W-1:0] rdata_o
);

  logic [tgcs_pkg::CHAR_W-1:0] mem_q [tgcs_pkg::DEPTH];
  logic [tgcs_pkg::CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/text_grid_cursor_scroll.sv */
// ---------------------------------------------------------------------------
// text_grid_cursor_scroll
// Character grid with a cursor, newline scrolling and fill for a small panel.
// ---------------------------------------------------------------------------
// Requests enter on the in_* valid/ready channel, each one operation: put a
// character, set cursor position, row or column, fill, blank or read a cell.
// Every request gives one response on the out_* valid/ready channel with the
// cell read, the cursor after the operation and a dropped flag.
// Fill and blank write every cell of the store, one cell per cycle; a newline
// on the last row copies the grid one row up, one cell per cycle through the
// store's read and write ports. An in-grid read passes through a read state.
// A plain put or cursor request can be taken every cycle while the block is
// idle and the response registers have room.
// Configuration writes take effect at once on the write port; the grid size
// is then recomputed by two 10-step dividers, and requests wait until done.
// After reset the store is cleared to the blank character by a pass over
// every cell; no request is taken during it.
// A response waits in a skid register while the next request is worked on;
// when both the output and skid registers are full and out_ready_i is low, in_ready_o drops.
// ---------------------------------------------------------------------------
module text_grid_cursor_scroll (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tgcs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tgcs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tgcs_pkg::OP_W-1:0]       opcode_i,
  input  logic [tgcs_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tgcs_pkg::IDX_W-1:0]      col_index_i,
  input  logic [tgcs_pkg::IDX_W-1:0]      row_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tgcs_pkg::CHAR_W-1:0]     cell_value_o,
  output logic [tgcs_pkg::ROW_W-1:0]      cursor_row_o,
  output logic [tgcs_pkg::COL_W-1:0]      cursor_col_o,
  output logic                           dropped_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;

  localparam int CW = tgcs_pkg::CNT_W;
  localparam int AW = tgcs_pkg::ADDR_W;
  localparam int PW = tgcs_pkg::PANEL_W;

  function automatic logic [PW:0] cell_count(input logic [PW-1:0] q, input logic nz,
                                             input logic part, input logic [PW:0] cap);
    logic [PW:0] n;
    begin
      n = {1'b0, q} + {{PW{1'b0}}, part & nz};
      if (n > cap) n = cap;
      if (n == '0) n = (PW + 1)'(1);
      return n;
    end
  endfunction

  // configuration
  logic [tgcs_pkg::FONT_W-1:0]  font_w_q, font_h_q;
  logic [PW-1:0]               panel_w_q, panel_h_q;
  logic                        partial_q;
  logic [tgcs_pkg::CHAR_W-1:0] blank_q;
  logic                        geom_start_q;
  tgcs_pkg::div_res_t          col_res, row_res;

  // grid and cursor
  logic [tgcs_pkg::NROW_W-1:0] rows_q, rows_new;
  logic [tgcs_pkg::NCOL_W-1:0] cols_q, cols_new;
  logic [tgcs_pkg::ROW_W-1:0]  row_pos_q, row_pos_d;
  logic [tgcs_pkg::COL_W-1:0]  col_pos_q, col_pos_d;

  // sequencer
  logic [2:0]                  state_q, state_d;
  logic [CW-1:0]               cnt_q, cnt_d, end_q, end_d, keep_q, keep_d;
  logic [tgcs_pkg::CHAR_W-1:0] sweep_val_q, sweep_val_d;
  logic                        pend_valid_q, pend_valid_d;
  logic [AW-1:0]               pend_addr_q, pend_addr_d;
  logic                        pend_rd_q, pend_rd_d;

  // memory port
  logic                        put_we;
  logic [AW-1:0]               put_addr, req_addr;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [tgcs_pkg::CHAR_W-1:0] mem_wdata, mem_rdata;

  // response path
  logic                        res_valid_q;
  logic [tgcs_pkg::CHAR_W-1:0] res_val_q, res_val_d;
  logic [tgcs_pkg::ROW_W-1:0]  res_row_q;
  logic [tgcs_pkg::COL_W-1:0]  res_col_q;
  logic                        res_drop_q, res_drop_d;
  logic                        res_load, res_move, res_free;
  logic                        out_valid_q;
  logic [tgcs_pkg::CHAR_W-1:0] out_val_q;
  logic [tgcs_pkg::ROW_W-1:0]  out_row_q;
  logic [tgcs_pkg::COL_W-1:0]  out_col_q;
  logic                        out_drop_q;

  logic geom_busy, in_acc, sweeping, in_grid;
  logic [tgcs_pkg::IDX_W-1:0] row_cl, col_cl;

  // ---------------- configuration and grid size ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_w_q     <= tgcs_pkg::FONT_W'(tgcs_pkg::FONT_W_RST);
      font_h_q     <= tgcs_pkg::FONT_W'(tgcs_pkg::FONT_H_RST);
      panel_w_q    <= PW'(tgcs_pkg::PANEL_W_RST);
      panel_h_q    <= PW'(tgcs_pkg::PANEL_H_RST);
      partial_q    <= 1'b0;
      blank_q      <= tgcs_pkg::BLANK_RST;
      geom_start_q <= 1'b0;
    end else begin
      geom_start_q <= cfg_we_i &&
                      (cfg_index_i inside {[tgcs_pkg::CFG_FONT_W:tgcs_pkg::CFG_BLANK]});
      if (cfg_we_i) begin
        case (cfg_index_i)
          tgcs_pkg::CFG_FONT_W:  font_w_q  <= cfg_data_i[tgcs_pkg::FONT_W-1:0];
          tgcs_pkg::CFG_FONT_H:  font_h_q  <= cfg_data_i[tgcs_pkg::FONT_W-1:0];
          tgcs_pkg::CFG_PANEL_W: panel_w_q <= cfg_data_i[PW-1:0];
          tgcs_pkg::CFG_PANEL_H: panel_h_q <= cfg_data_i[PW-1:0];
          tgcs_pkg::CFG_PARTIAL: partial_q <= cfg_data_i[0];
          tgcs_pkg::CFG_BLANK:   blank_q   <= cfg_data_i[tgcs_pkg::CHAR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  tgcs_div u_col_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (geom_start_q),
    .dividend_i (panel_w_q),
    .divisor_i  (font_w_q),
    .res_o      (col_res)
  );

  tgcs_div u_row_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (geom_start_q),
    .dividend_i (panel_h_q),
    .divisor_i  (font_h_q),
    .res_o      (row_res)
  );

  assign rows_new = tgcs_pkg::NROW_W'(cell_count(row_res.quot, row_res.rem_nz, partial_q,
                                                 (PW + 1)'(tgcs_pkg::MAX_ROWS)));
  assign cols_new = tgcs_pkg::NCOL_W'(cell_count(col_res.quot, col_res.rem_nz, partial_q,
                                                 (PW + 1)'(tgcs_pkg::MAX_COLUMNS)));

  assign geom_busy = geom_start_q || col_res.busy || row_res.busy ||
                     col_res.done || row_res.done;

  // ---------------- request control ----------------
  assign res_move   = !out_valid_q || out_ready_i;
  assign res_free   = !res_valid_q || res_move;
  assign in_ready_o = (state_q == ST_IDLE) && !geom_busy && res_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign sweeping   = (state_q == ST_INIT) || (state_q == ST_FILL) ||
                      (state_q == ST_SCROLL);

  assign row_cl = (row_index_i < tgcs_pkg::IDX_W'(rows_q)) ? row_index_i :
                  tgcs_pkg::IDX_W'(rows_q) - tgcs_pkg::IDX_W'(1);
  assign col_cl = (col_index_i < tgcs_pkg::IDX_W'(cols_q)) ? col_index_i :
                  tgcs_pkg::IDX_W'(cols_q) - tgcs_pkg::IDX_W'(1);
  assign in_grid = (row_index_i < tgcs_pkg::IDX_W'(rows_q)) &&
                   (col_index_i < tgcs_pkg::IDX_W'(cols_q));

  assign put_addr = AW'(row_pos_q) * AW'(tgcs_pkg::MAX_COLUMNS) + AW'(col_pos_q);
  assign req_addr = AW'(row_index_i) * AW'(tgcs_pkg::MAX_COLUMNS) + AW'(col_index_i);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    end_d        = end_q;
    keep_d       = keep_q;
    sweep_val_d  = sweep_val_q;
    row_pos_d    = row_pos_q;
    col_pos_d    = col_pos_q;
    pend_valid_d = 1'b0;
    pend_addr_d  = cnt_q[AW-1:0];
    pend_rd_d    = 1'b0;
    put_we       = 1'b0;
    res_load     = 1'b0;
    res_val_d    = '0;
    res_drop_d   = 1'b0;

    // new grid size: pull the cursor back inside
    if (col_res.done && row_res.done) begin
      if (tgcs_pkg::NROW_W'(row_pos_q) >= rows_new) begin
        row_pos_d = tgcs_pkg::ROW_W'(rows_new - tgcs_pkg::NROW_W'(1));
      end
      if (tgcs_pkg::NCOL_W'(col_pos_q) > cols_new) begin
        col_pos_d = tgcs_pkg::COL_W'(cols_new);
      end
    end

    case (state_q)
      ST_INIT, ST_FILL, ST_SCROLL: begin
        if (cnt_q != end_q) begin
          pend_valid_d = 1'b1;
          pend_addr_d  = cnt_q[AW-1:0];
          pend_rd_d    = (state_q == ST_SCROLL) && (cnt_q < keep_q);
          cnt_d        = cnt_q + CW'(1);
        end else begin
          state_d  = ST_IDLE;
          res_load = (state_q != ST_INIT);
        end
      end
      ST_READ: begin
        res_load  = 1'b1;
        res_val_d = mem_rdata;
        state_d   = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            tgcs_pkg::OP_PUT: begin
              if (char_code_i == tgcs_pkg::NEWLINE_CHAR) begin
                col_pos_d = '0;
                if (tgcs_pkg::NROW_W'(row_pos_q) + tgcs_pkg::NROW_W'(1) >= rows_q) begin
                  state_d     = ST_SCROLL;
                  cnt_d       = '0;
                  end_d       = CW'(rows_q) * CW'(tgcs_pkg::MAX_COLUMNS);
                  keep_d      = CW'(rows_q - tgcs_pkg::NROW_W'(1)) *
                                CW'(tgcs_pkg::MAX_COLUMNS);
                  sweep_val_d = blank_q;
                end else begin
                  row_pos_d = row_pos_q + tgcs_pkg::ROW_W'(1);
                  res_load  = 1'b1;
                end
              end else if (tgcs_pkg::NCOL_W'(col_pos_q) < cols_q) begin
                put_we    = 1'b1;
                col_pos_d = col_pos_q + tgcs_pkg::COL_W'(1);
                res_load  = 1'b1;
              end else begin
                res_drop_d = 1'b1;
                res_load   = 1'b1;
              end
            end
            tgcs_pkg::OP_SET_POS: begin
              row_pos_d = tgcs_pkg::ROW_W'(row_cl);
              col_pos_d = tgcs_pkg::COL_W'(col_cl);
              res_load  = 1'b1;
            end
            tgcs_pkg::OP_SET_ROW: begin
              row_pos_d = tgcs_pkg::ROW_W'(row_cl);
              res_load  = 1'b1;
            end
            tgcs_pkg::OP_SET_COL: begin
              col_pos_d = tgcs_pkg::COL_W'(col_cl);
              res_load  = 1'b1;
            end
            tgcs_pkg::OP_FILL: begin
              state_d     = ST_FILL;
              cnt_d       = '0;
              end_d       = CW'(tgcs_pkg::DEPTH);
              sweep_val_d = char_code_i;
            end
            tgcs_pkg::OP_BLANK: begin
              state_d     = ST_FILL;
              cnt_d       = '0;
              end_d       = CW'(tgcs_pkg::DEPTH);
              sweep_val_d = blank_q;
            end
            tgcs_pkg::OP_READ: begin
              if (in_grid) begin
                state_d = ST_READ;
              end else begin
                res_val_d = blank_q;
                res_load  = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      end_q        <= CW'(tgcs_pkg::DEPTH);
      keep_q       <= '0;
      sweep_val_q  <= tgcs_pkg::BLANK_RST;
      pend_valid_q <= 1'b0;
      pend_addr_q  <= '0;
      pend_rd_q    <= 1'b0;
      rows_q       <= tgcs_pkg::NROW_W'(tgcs_pkg::ROWS_RST);
      cols_q       <= tgcs_pkg::NCOL_W'(tgcs_pkg::COLS_RST);
      row_pos_q    <= '0;
      col_pos_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      end_q        <= end_d;
      keep_q       <= keep_d;
      sweep_val_q  <= sweep_val_d;
      pend_valid_q <= pend_valid_d;
      pend_addr_q  <= pend_addr_d;
      pend_rd_q    <= pend_rd_d;
      row_pos_q    <= row_pos_d;
      col_pos_q    <= col_pos_d;
      if (col_res.done && row_res.done) begin
        rows_q <= rows_new;
        cols_q <= cols_new;
      end
    end
  end

  // ---------------- cell store ----------------
  assign mem_we    = pend_valid_q || put_we;
  assign mem_waddr = pend_valid_q ? pend_addr_q : put_addr;
  assign mem_wdata = pend_valid_q ? (pend_rd_q ? mem_rdata : sweep_val_q) : char_code_i;
  assign mem_raddr = sweeping ? (cnt_q[AW-1:0] + AW'(tgcs_pkg::MAX_COLUMNS)) : req_addr;

  tgcs_cell_ram u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------- response skid and output registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_val_q   <= '0;
      res_row_q   <= '0;
      res_col_q   <= '0;
      res_drop_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_drop_q  <= 1'b0;
    end else begin
      if (res_move) begin
        out_valid_q <= res_valid_q;
        if (res_valid_q) begin
          out_val_q  <= res_val_q;
          out_row_q  <= res_row_q;
          out_col_q  <= res_col_q;
          out_drop_q <= res_drop_q;
        end
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
        res_val_q   <= res_val_d;
        res_row_q   <= row_pos_d;
        res_col_q   <= col_pos_d;
        res_drop_q  <= res_drop_d;
      end else if (res_move) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_val_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign dropped_o    = out_drop_q;

`ifndef SYNTHESIS
  a_row_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tgcs_pkg::NROW_W'(row_pos_q) < rows_q)
    else $error("cursor row outside grid");

  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tgcs_pkg::NCOL_W'(col_pos_q) <= cols_q)
    else $error("cursor column beyond grid");

  a_skid_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || res_move))
    else $error("response overwrites a pending response");

  a_write_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_valid_q && put_we))
    else $error("sweep write collides with a put");

  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> $past(in_acc && opcode_i == tgcs_pkg::OP_READ))
    else $error("read wait without a read request");
`endif

endmodule
